/* design/assert_macros.svh */
// assertion macros shared by the list engine modules
// expects signals named clk and rst in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define PLE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/ple_pkg.sv */
// shared types and codes for the positional list engine
// no dependencies
`timescale 1ns / 1ps

package ple_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic take;    // latch the request beat
    logic check;   // classify the request, set up the walk
    logic step;    // issue one memory read of the walk
    logic place;   // write the new value or shrink the list
    logic finish;  // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic ok;        // request passes its checks
    logic more;      // walk still has entries to read
    logic pend;      // a read of the walk is still in flight
    logic out_free;  // result register can take a new beat
  } sts_t;

endpackage

/* design/ple_in_if.sv */
// request channel of the positional list engine
// depends on nothing
`timescale 1ns / 1ps

interface ple_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [6:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

/* design/ple_out_if.sv */
// response channel of the positional list engine
// depends on nothing
`timescale 1ns / 1ps

interface ple_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic               found;
  logic [1:0]         status;
  logic [6:0]         length;

  modport source (output valid, output read_value, output found, output status,
                  output length, input ready);
  modport sink   (input valid, input read_value, input found, input status,
                  input length, output ready);
endinterface

/* design/positional_list_engine_top.sv */
// top level of the positional list engine
// depends on ple_pkg, ple_in_if, ple_out_if, ple_ctrl and ple_datapath
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit entries, addressed by 1-based
// position. Each request beat carries one operation (insert before a
// position, remove at a position, get at a position, find a value) and
// produces exactly one response beat with the read value, the found flag,
// a status code and the list length after the operation. Entries live in a
// single-port-write, single-port-read memory with registered read data, so
// insert and remove move one entry per cycle and find compares one entry per
// cycle. One request is worked at a time: a failed request or a get goes from
// the check straight to the result, an insert or remove walks the entries
// that move and then places, and a find reads every stored entry. The next
// request is accepted as soon as the response is loaded into the output
// register, even if the consumer has not taken it yet. No clearing pass runs
// after reset; the memory is only read at positions already written, but for
// the read of a get with a bad position, whose data is not used.
module positional_list_engine_top #(
  parameter int CAPACITY = 64
) (
  input logic       clk,
  input logic       rst,
  ple_in_if.sink    req,
  ple_out_if.source rsp
);

  // command and status between controller and datapath
  ple_pkg::cmd_t cmd;
  ple_pkg::sts_t sts;

  // sequencing: accept, check, walk the memory, place, hand off result
  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // entry memory, entry count, walk index and the response register
  ple_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (req.op),
    .in_position    (req.position),
    .in_value       (req.value),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .out_read_value (rsp.read_value),
    .out_found      (rsp.found),
    .out_status     (rsp.status),
    .out_length     (rsp.length)
  );

endmodule

/* design/ple_datapath.sv */
// datapath of the positional list engine: entry memory, count, walk index, result register
// depends on ple_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ple_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  ple_pkg::cmd_t      cmd,
  output ple_pkg::sts_t      sts,
  input  logic [1:0]         in_op,
  input  logic [6:0]         in_position,
  input  logic signed [31:0] in_value,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] out_read_value,
  output logic               out_found,
  output logic [1:0]         out_status,
  output logic [6:0]         out_length
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > 7) ? CW : 7) + 1;

  logic [31:0]      mem [CAPACITY];
  logic [31:0]      rdata;

  ple_pkg::op_t     op_q;
  logic [6:0]       pos_q;
  logic [31:0]      val_q;
  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;
  logic [AW-1:0]    wr_addr;
  logic             pend;
  logic             found_q;
  ple_pkg::status_t st_q;

  ple_pkg::status_t st_now;
  logic [XW-1:0]    pos_x;
  logic [XW-1:0]    cnt_x;
  logic [XW-1:0]    idx_x;
  logic [6:0]       pos_m1;
  logic [CW-1:0]    rd_sel;
  logic             more;
  logic             re;
  logic [AW-1:0]    ra;
  logic             we;
  logic [AW-1:0]    wa;
  logic [31:0]      wd;
  logic             ins_place;

  assign pos_x  = XW'(pos_q);
  assign cnt_x  = XW'(count);
  assign idx_x  = XW'(idx);
  assign pos_m1 = pos_q - 7'd1;

  // request checks, in the order the list semantics give them
  always_comb begin
    st_now = ple_pkg::ST_OK;
    case (op_q)
      ple_pkg::OP_INSERT: begin
        if (pos_q == 7'd0 || pos_x > cnt_x + XW'(1)) st_now = ple_pkg::ST_BAD_POS;
        else if (cnt_x >= XW'(CAPACITY))           st_now = ple_pkg::ST_FULL;
      end
      ple_pkg::OP_REMOVE: begin
        if (count == '0)                            st_now = ple_pkg::ST_EMPTY;
        else if (pos_q == 7'd0 || pos_x > cnt_x)    st_now = ple_pkg::ST_BAD_POS;
      end
      ple_pkg::OP_GET: begin
        if (pos_q == 7'd0 || pos_x > cnt_x)         st_now = ple_pkg::ST_BAD_POS;
      end
      default: st_now = ple_pkg::ST_OK;
    endcase
  end

  // walk direction and end condition
  always_comb begin
    case (op_q)
      ple_pkg::OP_INSERT: begin
        more   = idx_x >= pos_x;
        rd_sel = idx - CW'(1);
      end
      ple_pkg::OP_REMOVE: begin
        more   = (idx_x + XW'(1)) < cnt_x;
        rd_sel = idx + CW'(1);
      end
      ple_pkg::OP_FIND: begin
        more   = idx_x < cnt_x;
        rd_sel = idx;
      end
      default: begin
        more   = 1'b0;
        rd_sel = idx;
      end
    endcase
  end

  assign ins_place = cmd.place && (op_q == ple_pkg::OP_INSERT);

  assign re = (cmd.check && op_q == ple_pkg::OP_GET) || cmd.step;
  assign ra = cmd.check ? AW'(pos_m1) : rd_sel[AW-1:0];
  assign we = ins_place ||
              (pend && (op_q == ple_pkg::OP_INSERT || op_q == ple_pkg::OP_REMOVE));
  assign wa = ins_place ? AW'(pos_m1) : wr_addr;
  assign wd = ins_place ? val_q : rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= cmd.step;
      if (cmd.place) begin
        count <= (op_q == ple_pkg::OP_INSERT) ? count + CW'(1) : count - CW'(1);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q  <= ple_pkg::op_t'(in_op);
      pos_q <= in_position;
      val_q <= in_value;
    end
    if (cmd.check) begin
      st_q    <= st_now;
      found_q <= 1'b0;
      case (op_q)
        ple_pkg::OP_INSERT: idx <= count;
        ple_pkg::OP_REMOVE: idx <= CW'(pos_m1);
        default:            idx <= '0;
      endcase
    end
    if (cmd.step) begin
      wr_addr <= idx[AW-1:0];
      idx     <= (op_q == ple_pkg::OP_INSERT) ? idx - CW'(1) : idx + CW'(1);
    end
    // compare the entry that was read on the previous cycle
    if (pend && op_q == ple_pkg::OP_FIND && rdata == val_q) begin
      found_q <= 1'b1;
    end
    if (cmd.finish) begin
      if (op_q == ple_pkg::OP_GET) begin
        out_read_value <= (st_q == ple_pkg::ST_OK) ? $signed(rdata) : -32'sd1;
      end else begin
        out_read_value <= '0;
      end
      out_found  <= (op_q == ple_pkg::OP_FIND) && found_q;
      out_status <= st_q;
      out_length <= 7'(count);
    end
  end

  assign sts.op       = op_q;
  assign sts.ok       = (st_now == ple_pkg::ST_OK);
  assign sts.more     = more;
  assign sts.pend     = pend;
  assign sts.out_free = !out_valid || out_ready;

  `PLE_ASSERT_ALWAYS(a_single_write, !(ins_place && pend), "insert write collides with shift write")
  `PLE_ASSERT_ALWAYS(a_count_bound, XW'(count) <= XW'(CAPACITY), "entry count above capacity")
  `PLE_ASSERT_NEXT(a_result_shown, cmd.finish, out_valid, "loaded result not presented")

endmodule

/* design/ple_ctrl.sv */
// controller state machine of the positional list engine
// depends on ple_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ple_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ple_pkg::sts_t sts,
  output ple_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_SHIFT  = 6'b000100,
    S_SCAN   = 6'b001000,
    S_PLACE  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.take   = (state == S_IDLE) && in_valid;
    cmd.check  = (state == S_CHECK);
    cmd.step   = (state == S_SHIFT || state == S_SCAN) && sts.more;
    cmd.place  = (state == S_PLACE);
    cmd.finish = (state == S_FINISH) && sts.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.ok) begin
          state_next = S_FINISH;
        end else begin
          case (sts.op)
            ple_pkg::OP_INSERT: state_next = S_SHIFT;
            ple_pkg::OP_REMOVE: state_next = S_SHIFT;
            ple_pkg::OP_FIND:   state_next = S_SCAN;
            default:            state_next = S_FINISH;
          endcase
        end
      end
      S_SHIFT: begin
        if (!sts.more) state_next = S_PLACE;
      end
      S_SCAN: begin
        if (!sts.more && !sts.pend) state_next = S_FINISH;
      end
      S_PLACE: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `PLE_ASSERT_NEXT(a_take_checks, cmd.take, state == S_CHECK, "accepted beat not checked next")

endmodule

/* tb/sv/tb.sv */
// self-checking testbench for the positional list engine
// depends on ple_pkg, ple_in_if, ple_out_if and positional_list_engine_top
`timescale 1ns / 1ps

module tb;

  localparam int CAPACITY    = 64;
  localparam int RANDOM_OPS  = 1300;
  localparam int IDLE_LIMIT  = 4000;       // cycles with no beat on either side
  localparam int SETTLE_WAIT = CAPACITY * 2 + 20;
  localparam int POOL_N      = 12;

  // one request beat as the stimulus sees it
  typedef struct {
    ple_pkg::op_t       op;
    logic [6:0]         position;
    logic signed [31:0] value;
    bit                 wait_idle;  // hold this beat until every reply is back
  } list_op_t;

  // one reply beat as the checker expects it
  typedef struct {
    logic signed [31:0] read_value;
    logic               found;
    ple_pkg::status_t   status;
    logic [6:0]         length;
  } list_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ple_in_if  req_if ();
  ple_out_if rsp_if ();

  positional_list_engine_top #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // list mirror: holds what the engine should store and predicts each reply
  // ---------------------------------------------------------------------------
  logic signed [31:0] mirror_entries [0:CAPACITY-1];
  int                 mirror_len = 0;

  list_op_t    queued_ops [$];        // beats not yet accepted by the engine
  list_reply_t predicted_replies [$]; // replies owed by the engine, oldest first
  int          ops_accepted   = 0;
  int          replies_taken  = 0;
  int          mismatch_count = 0;

  // apply one operation to the mirror and return the reply it must produce
  function automatic list_reply_t apply_list_op(input list_op_t o);
    list_reply_t r;
    int p;
    int k;
    p            = int'(o.position);
    r.read_value = '0;
    r.found      = 1'b0;
    r.status     = ple_pkg::ST_OK;
    case (o.op)
      ple_pkg::OP_INSERT: begin
        // position is judged before fullness
        if (p < 1 || p > mirror_len + 1) begin
          r.status = ple_pkg::ST_BAD_POS;
        end else if (mirror_len >= CAPACITY) begin
          r.status = ple_pkg::ST_FULL;
        end else begin
          for (k = mirror_len; k >= p; k--) mirror_entries[k] = mirror_entries[k - 1];
          mirror_entries[p - 1] = o.value;
          mirror_len++;
        end
      end
      ple_pkg::OP_REMOVE: begin
        // emptiness is judged before the position
        if (mirror_len == 0) begin
          r.status = ple_pkg::ST_EMPTY;
        end else if (p < 1 || p > mirror_len) begin
          r.status = ple_pkg::ST_BAD_POS;
        end else begin
          for (k = p - 1; k + 1 < mirror_len; k++) mirror_entries[k] = mirror_entries[k + 1];
          mirror_len--;
        end
      end
      ple_pkg::OP_GET: begin
        if (p < 1 || p > mirror_len) begin
          r.read_value = -32'sd1;
          r.status     = ple_pkg::ST_BAD_POS;
        end else begin
          r.read_value = mirror_entries[p - 1];
        end
      end
      ple_pkg::OP_FIND: begin
        for (k = 0; k < mirror_len; k++) begin
          if (mirror_entries[k] == o.value) r.found = 1'b1;
        end
      end
      default: r.status = ple_pkg::ST_OK;
    endcase
    r.length = 7'(mirror_len);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("mismatch at reply %0d: %s got %h want %h", replies_taken, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builder: tracks only the list length so positions land where
  // they matter (inside the list, at its ends, just past it, anywhere)
  // ---------------------------------------------------------------------------
  int                 build_len = 0;
  bit                 hold_next = 1'b0;
  int                 seq_count = 0;
  int                 directed_n;
  logic signed [31:0] value_pool [0:POOL_N-1];

  task automatic add_op(input ple_pkg::op_t op, input int pos, input logic [31:0] val);
    list_op_t o;
    o.op        = op;
    o.position  = 7'(pos);
    o.value     = val;
    o.wait_idle = hold_next;
    hold_next   = 1'b0;
    queued_ops.push_back(o);
    if (op == ple_pkg::OP_INSERT && pos >= 1 && pos <= build_len + 1 && build_len < CAPACITY)
      build_len++;
    else if (op == ple_pkg::OP_REMOVE && build_len > 0 && pos >= 1 && pos <= build_len)
      build_len--;
  endtask

  // mostly a valid position in 1..hi, otherwise zero, one past, or anything
  function automatic int pick_pos(input int hi);
    int r;
    r = $urandom_range(0, 9);
    if (hi >= 1 && r < 7) return $urandom_range(1, hi);
    case (r)
      7:       return 0;
      8:       return hi + 1;
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  // pool values make finds hit; raw values exercise every bit
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 1) == 1) return value_pool[$urandom_range(0, POOL_N - 1)];
    return $urandom;
  endfunction

  // grow to capacity, then knock on the full list
  task automatic seq_fill();
    while (build_len < CAPACITY)
      add_op(ple_pkg::OP_INSERT, $urandom_range(1, build_len + 1), pick_value());
    add_op(ple_pkg::OP_INSERT, 1, pick_value());
    add_op(ple_pkg::OP_INSERT, CAPACITY + 1, pick_value());
    // bad wins over full
    add_op(ple_pkg::OP_INSERT, $urandom_range(CAPACITY + 2, 127), pick_value());
    add_op(ple_pkg::OP_GET, CAPACITY, 0);
    add_op(ple_pkg::OP_GET, CAPACITY + 1, 0);
    add_op(ple_pkg::OP_FIND, 0, pick_value());
  endtask

  // empty the list, then hit the empty cases
  task automatic seq_drain();
    int r;
    while (build_len > 0) begin
      r = $urandom_range(0, 9);
      if (r < 8) add_op(ple_pkg::OP_REMOVE, $urandom_range(1, build_len), 0);
      else if (r == 8) add_op(ple_pkg::OP_GET, pick_pos(build_len), 0);
      else add_op(ple_pkg::OP_FIND, 0, pick_value());
    end
    add_op(ple_pkg::OP_REMOVE, 1, 0);
    add_op(ple_pkg::OP_REMOVE, $urandom_range(0, 127), 0);
    add_op(ple_pkg::OP_GET, 1, 0);
    add_op(ple_pkg::OP_FIND, 0, pick_value());
  endtask

  task automatic seq_mixed();
    int n;
    int r;
    int ins_w;
    n = $urandom_range(10, 40);
    repeat (n) begin
      ins_w = (build_len < 8) ? 55 : ((build_len > 56) ? 15 : 30);
      r     = $urandom_range(0, 99);
      if (r < ins_w) add_op(ple_pkg::OP_INSERT, pick_pos(build_len + 1), pick_value());
      else if (r < ins_w + 25) add_op(ple_pkg::OP_REMOVE, pick_pos(build_len), 0);
      else if (r < ins_w + 50) add_op(ple_pkg::OP_GET, pick_pos(build_len), $urandom);
      else add_op(ple_pkg::OP_FIND, $urandom_range(0, 127), pick_value());
    end
  endtask

  task automatic seq_lookup();
    int n;
    n = $urandom_range(8, 20);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) add_op(ple_pkg::OP_GET, pick_pos(build_len), 0);
      else add_op(ple_pkg::OP_FIND, $urandom_range(0, 127), pick_value());
    end
  endtask

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length with random gaps; a beat marked
  // wait_idle is held back until the engine owes nothing
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;
  bit req_fire;

  always @(posedge clk) begin
    if (rst) begin
      req_if.valid    <= 1'b0;
      req_if.op       <= ple_pkg::OP_INSERT;
      req_if.position <= '0;
      req_if.value    <= '0;
    end else begin
      req_fire = req_if.valid && req_if.ready;
      if (req_fire) begin
        predicted_replies.push_back(apply_list_op(queued_ops.pop_front()));
        ops_accepted <= ops_accepted + 1;
      end
      // a beat on offer that was not taken stays as it is
      if (!req_if.valid || req_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (queued_ops.size() != 0 &&
                     !(queued_ops[0].wait_idle && (req_fire || ops_accepted != replies_taken))) begin
          req_if.valid    <= 1'b1;
          req_if.op       <= queued_ops[0].op;
          req_if.position <= queued_ops[0].position;
          req_if.value    <= queued_ops[0].value;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            // a third of the bursts run straight into the next one
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // reply side: ready follows a mode that is redrawn at random whenever its timer runs out of cycles
  // ---------------------------------------------------------------------------
  int stall_mode  = 0;
  int stall_timer = 0;
  int stall_phase = 0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (stall_timer == 0) begin
        stall_mode  = $urandom_range(0, 3);
        stall_timer = $urandom_range(64, 512);
      end
      stall_timer--;
      stall_phase++;
      case (stall_mode)
        0:       rsp_if.ready <= 1'b1;                           // never stall
        1:       rsp_if.ready <= 1'($urandom_range(0, 1));      // coin flip
        2:       rsp_if.ready <= (stall_phase % 7) < 4;          // fixed rhythm
        default: rsp_if.ready <= ($urandom_range(0, 4) == 0);    // mostly stalled
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // reply checker: every reply beat against the oldest prediction
  // ---------------------------------------------------------------------------
  list_reply_t want;

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      replies_taken <= replies_taken + 1;
      if (predicted_replies.size() == 0) begin
        flag_mismatch("reply with nothing outstanding", rsp_if.read_value, '0);
      end else begin
        want = predicted_replies.pop_front();
        if (rsp_if.read_value !== want.read_value)
          flag_mismatch("read_value", rsp_if.read_value, want.read_value);
        if (rsp_if.found !== want.found)
          flag_mismatch("found", 32'(rsp_if.found), 32'(want.found));
        if (rsp_if.status !== want.status)
          flag_mismatch("status", 32'(rsp_if.status), 32'(want.status));
        if (rsp_if.length !== want.length)
          flag_mismatch("length", 32'(rsp_if.length), 32'(want.length));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: a hung handshake ends the run
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    req_if.valid    = 1'b0;
    req_if.op       = ple_pkg::OP_INSERT;
    req_if.position = '0;
    req_if.value    = '0;
    rsp_if.ready    = 1'b0;

    value_pool[0] = 32'sh0000_0000;
    value_pool[1] = 32'shFFFF_FFFF;
    value_pool[2] = 32'sh8000_0000;
    value_pool[3] = 32'sh7FFF_FFFF;
    value_pool[4] = 32'sh0000_0001;
    for (int i = 5; i < POOL_N; i++) value_pool[i] = $urandom;

    // directed: empty list cases first
    add_op(ple_pkg::OP_REMOVE, 1, 0);                  // remove from empty
    add_op(ple_pkg::OP_REMOVE, 0, 0);                  // empty is judged before the position
    add_op(ple_pkg::OP_GET, 1, 0);                     // get on empty
    add_op(ple_pkg::OP_FIND, 0, 32'h0000_0000);        // find on empty
    add_op(ple_pkg::OP_INSERT, 0, 32'h1111_1111);      // position zero
    add_op(ple_pkg::OP_INSERT, 2, 32'h2222_2222);      // past count plus one
    // build [-1, 0, min, max] through front, end and middle inserts
    add_op(ple_pkg::OP_INSERT, 1, 32'h8000_0000);
    add_op(ple_pkg::OP_INSERT, 2, 32'h7FFF_FFFF);
    add_op(ple_pkg::OP_INSERT, 1, 32'hFFFF_FFFF);
    add_op(ple_pkg::OP_INSERT, 2, 32'h0000_0000);
    add_op(ple_pkg::OP_INSERT, 127, 32'h3333_3333);    // widest position field
    add_op(ple_pkg::OP_GET, 1, 0);
    add_op(ple_pkg::OP_GET, 4, 0);
    add_op(ple_pkg::OP_GET, 5, 0);
    add_op(ple_pkg::OP_GET, 0, 0);
    add_op(ple_pkg::OP_GET, 127, 0);
    add_op(ple_pkg::OP_FIND, 0, 32'h8000_0000);
    add_op(ple_pkg::OP_FIND, 0, 32'h8000_0001);        // one bit off must miss
    add_op(ple_pkg::OP_FIND, 0, 32'h7FFF_FFFF);        // hit on the last entry
    add_op(ple_pkg::OP_REMOVE, 5, 0);
    add_op(ple_pkg::OP_REMOVE, 0, 0);
    add_op(ple_pkg::OP_REMOVE, 2, 0);                  // middle
    add_op(ple_pkg::OP_REMOVE, 3, 0);                  // last
    add_op(ple_pkg::OP_FIND, 0, 32'h0000_0000);        // removed value is gone
    add_op(ple_pkg::OP_GET, 2, 0);
    directed_n = queued_ops.size();

    // random part opens with a full list after a pause for the directed replies
    hold_next = 1'b1;
    seq_fill();
    while (queued_ops.size() < directed_n + RANDOM_OPS) begin
      seq_count++;
      if (seq_count % 4 == 0) hold_next = 1'b1;
      case ($urandom_range(0, 9))
        0, 1:    seq_fill();
        2, 3:    seq_drain();
        4:       seq_lookup();
        default: seq_mixed();
      endcase
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // sample away from the active edge so counters and queues are settled
    do @(negedge clk); while (queued_ops.size() != 0 || ops_accepted != replies_taken);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (predicted_replies.size() != 0)
      flag_mismatch("replies never came", '0, predicted_replies.size());

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
